// ----- src/vps_pkg.sv -----
// shared types and constants of the verlet particle step core
// no dependencies; imported by verlet_particle_step_core
package vps_pkg;

  // configuration register index, taken from the word address
  typedef enum logic [1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_GRID_WIDTH  = 2'd1,
    REG_GRID_HEIGHT = 2'd2
  } reg_index_t;

  // damping constants, unsigned q0.16
  localparam int          CONST_FRAC = 16;
  localparam logic [15:0] K_FORCE    = 16'd55706;  // 0.85
  localparam logic [15:0] K_MOTION   = 16'd65405;  // 0.998

  localparam int          GRID_W     = 9;
  localparam logic [8:0]  GRID_RESET = 9'd64;
  localparam int          CELL_W     = 16;

endpackage

// ----- src/verlet_particle_step_core.sv -----
// damped verlet step for one 2d particle per beat, six-stage pipeline
// depends on vps_pkg (register indexes, damping constants)
//
// One particle enters per clock unless item_stall is raised, and the
// pipeline takes a new beat every cycle and only stalls its input when the
// result register is held and every stage behind it is full. The stages are:
// force and motion damping multiplies, rounding plus base position, the
// force times dt squared multiply (the widest unit, it sets the clock), the
// rounding and saturation of that term, the sum and box clamp, and the cell
// index multiply-add. dt squared and the clamp bounds are kept in registers
// derived from the configuration registers through dt_sq, gw_eff and gh_eff.
module verlet_particle_step_core #(
  parameter int POS_INT_BITS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic clk,
  input  logic rst,
  // configuration port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [((POS_INT_BITS + FRAC_BITS > 32) ? 5 : 4)-1:0] paddr,
  input  logic [((POS_INT_BITS + FRAC_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((POS_INT_BITS + FRAC_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic pready,
  // particle in
  input  logic item_valid,
  output logic item_stall,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0] pos_x,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0] pos_y,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0] prev_x,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0] prev_y,
  input  logic signed [POS_INT_BITS+FRAC_BITS-1:0] force_x,
  input  logic signed [POS_INT_BITS+FRAC_BITS-1:0] force_y,
  // particle out
  output logic result_valid,
  input  logic result_stall,
  output logic [POS_INT_BITS+FRAC_BITS-1:0] new_pos_x,
  output logic [POS_INT_BITS+FRAC_BITS-1:0] new_pos_y,
  output logic [POS_INT_BITS+FRAC_BITS-1:0] new_prev_x,
  output logic [POS_INT_BITS+FRAC_BITS-1:0] new_prev_y,
  output logic signed [POS_INT_BITS+FRAC_BITS-1:0] new_force_x,
  output logic signed [POS_INT_BITS+FRAC_BITS-1:0] new_force_y,
  output logic [vps_pkg::CELL_W-1:0] cell_index
);
  import vps_pkg::*;

  localparam int W      = POS_INT_BITS + FRAC_BITS;
  localparam int F      = FRAC_BITS;
  localparam int PDW    = (W > 32) ? 64 : 32;
  localparam int ASH    = (W > 32) ? 3 : 2;
  localparam int ADDR_W = ASH + 2;
  localparam int NS     = 6;
  localparam int KPW    = W + CONST_FRAC;     // damping product
  localparam int DTW    = W + 3;              // dt squared, saturated
  localparam int APW    = W + DTW;            // force term product
  localparam int UBW    = F + GRID_W + POS_INT_BITS;
  localparam int SUMW   = POS_INT_BITS + GRID_W + 1;

  localparam logic [KPW-1:0]     RND_K    = KPW'(1) << (CONST_FRAC - 1);
  localparam logic [2*W:0]       RND_DT   = (2*W+1)'(1) << (F - 1);
  localparam logic [APW-1:0]     RND_A    = APW'(1) << (F - 1);
  localparam logic [DTW-1:0]     CAP      = DTW'(1) << (W + 2);
  localparam logic [W-1:0]       HALF     = W'(1) << (F - 1);
  localparam logic [W-1:0]       POS_MAX  = {W{1'b1}};
  localparam logic [UBW-1:0]     HALF_U   = UBW'(1) << (F - 1);

  // ---------------------------------------------------------------
  // configuration registers and derived constants
  // ---------------------------------------------------------------
  logic [W-1:0]      time_step;
  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [GRID_W-1:0] gw_eff;
  logic [GRID_W-1:0] gh_eff;
  logic [2*W-1:0]    dt_sq;
  logic [DTW-1:0]    dt2;
  logic [W-1:0]      ub [2];

  reg_index_t reg_idx;
  logic       cfg_wr;
  logic [2*W:0]   dt_rnd;
  logic [UBW-1:0] ub_raw [2];

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[ADDR_W-1:ASH]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_TIME_STEP:   prdata = PDW'(time_step);
      REG_GRID_WIDTH:  prdata = PDW'(grid_width);
      REG_GRID_HEIGHT: prdata = PDW'(grid_height);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= W'(1) << F;
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TIME_STEP:   time_step   <= pwdata[W-1:0];
        REG_GRID_WIDTH:  grid_width  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero grid size counts as one cell
  assign dt_rnd    = ({1'b0, dt_sq} + RND_DT) >> F;
  assign ub_raw[0] = ({UBW'(gw_eff)} << F) - HALF_U;
  assign ub_raw[1] = ({UBW'(gh_eff)} << F) - HALF_U;

  always_ff @(posedge clk) begin
    gw_eff <= (grid_width  == '0) ? GRID_W'(1) : grid_width;
    gh_eff <= (grid_height == '0) ? GRID_W'(1) : grid_height;
    dt_sq  <= (2*W)'(time_step) * (2*W)'(time_step);
    dt2    <= (dt_rnd > (2*W+1)'(CAP)) ? CAP : dt_rnd[DTW-1:0];
    for (int a = 0; a < 2; a++) begin
      ub[a] <= (ub_raw[a] > UBW'(POS_MAX)) ? POS_MAX : ub_raw[a][W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v[NS-1] || !result_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign item_stall   = !rdy[0];
  assign result_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= item_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // datapath, one lane per axis
  // ---------------------------------------------------------------
  logic [W-1:0]        in_pos   [2];
  logic [W-1:0]        in_prev  [2];
  logic signed [W-1:0] in_force [2];

  assign in_pos[0]   = pos_x;
  assign in_pos[1]   = pos_y;
  assign in_prev[0]  = prev_x;
  assign in_prev[1]  = prev_y;
  assign in_force[0] = force_x;
  assign in_force[1] = force_y;

  // stage 1: damping multiplies on magnitudes
  logic [W-1:0] f_mag [2];
  logic [W:0]   d_ext [2];
  logic [W-1:0] d_mag [2];

  logic [KPW-1:0] s1_fprod [2];
  logic [KPW-1:0] s1_mprod [2];
  logic           s1_fneg  [2];
  logic           s1_mneg  [2];
  logic [W-1:0]   s1_pos   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      f_mag[a] = in_force[a][W-1] ? (~in_force[a] + W'(1)) : in_force[a];
      d_ext[a] = {1'b0, in_pos[a]} - {1'b0, in_prev[a]};
      d_mag[a] = d_ext[a][W] ? W'(~d_ext[a] + (W+1)'(1)) : d_ext[a][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && item_valid) begin
      for (int a = 0; a < 2; a++) begin
        s1_fprod[a] <= KPW'(f_mag[a]) * KPW'(K_FORCE);
        s1_mprod[a] <= KPW'(d_mag[a]) * KPW'(K_MOTION);
        s1_fneg[a]  <= in_force[a][W-1];
        s1_mneg[a]  <= d_ext[a][W];
        s1_pos[a]   <= in_pos[a];
      end
    end
  end

  // stage 2: round, apply signs, base position pos + motion
  logic [KPW-1:0]        fd_r [2];
  logic [KPW-1:0]        mv_r [2];
  logic signed [W+1:0]   mv_s [2];

  logic [W-1:0]          s2_fdmag [2];
  logic                  s2_fneg  [2];
  logic signed [W-1:0]   s2_force [2];
  logic signed [W+1:0]   s2_base  [2];
  logic [W-1:0]          s2_pos   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fd_r[a] = (s1_fprod[a] + RND_K) >> CONST_FRAC;
      mv_r[a] = (s1_mprod[a] + RND_K) >> CONST_FRAC;
      mv_s[a] = s1_mneg[a] ? -signed'((W+2)'(mv_r[a][W-1:0]))
                           :  signed'((W+2)'(mv_r[a][W-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      for (int a = 0; a < 2; a++) begin
        s2_fdmag[a] <= fd_r[a][W-1:0];
        s2_fneg[a]  <= s1_fneg[a];
        s2_force[a] <= s1_fneg[a] ? -signed'(fd_r[a][W-1:0]) : signed'(fd_r[a][W-1:0]);
        s2_base[a]  <= signed'({2'b00, s1_pos[a]}) + mv_s[a];
        s2_pos[a]   <= s1_pos[a];
      end
    end
  end

  // stage 3: damped force times dt squared
  logic [APW-1:0]        s3_aprod [2];
  logic                  s3_fneg  [2];
  logic signed [W-1:0]   s3_force [2];
  logic signed [W+1:0]   s3_base  [2];
  logic [W-1:0]          s3_pos   [2];

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      for (int a = 0; a < 2; a++) begin
        s3_aprod[a] <= APW'(s2_fdmag[a]) * APW'(dt2);
        s3_fneg[a]  <= s2_fneg[a];
        s3_force[a] <= s2_force[a];
        s3_base[a]  <= s2_base[a];
        s3_pos[a]   <= s2_pos[a];
      end
    end
  end

  // stage 4: round and saturate the force term
  logic [APW-1:0] acc_r   [2];
  logic [DTW-1:0] acc_mag [2];

  logic signed [W+3:0]   s4_acc   [2];
  logic signed [W-1:0]   s4_force [2];
  logic signed [W+1:0]   s4_base  [2];
  logic [W-1:0]          s4_pos   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      acc_r[a]   = (s3_aprod[a] + RND_A) >> F;
      acc_mag[a] = (acc_r[a] > APW'(CAP)) ? CAP : acc_r[a][DTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      for (int a = 0; a < 2; a++) begin
        s4_acc[a]   <= s3_fneg[a] ? -signed'((W+4)'(acc_mag[a]))
                                  :  signed'((W+4)'(acc_mag[a]));
        s4_force[a] <= s3_force[a];
        s4_base[a]  <= s3_base[a];
        s4_pos[a]   <= s3_pos[a];
      end
    end
  end

  // stage 5: sum and clamp into the box
  logic signed [W+3:0] raw    [2];
  logic signed [W+3:0] ub_s   [2];
  logic [W-1:0]        clamped [2];

  logic [W-1:0]          s5_npos  [2];
  logic signed [W-1:0]   s5_force [2];
  logic [W-1:0]          s5_pos   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      raw[a]  = (W+4)'(s4_base[a]) + s4_acc[a];
      ub_s[a] = signed'((W+4)'(ub[a]));
      if (raw[a] < signed'((W+4)'(HALF))) begin
        clamped[a] = HALF;
      end else if (raw[a] > ub_s[a]) begin
        clamped[a] = ub[a];
      end else begin
        clamped[a] = raw[a][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      for (int a = 0; a < 2; a++) begin
        s5_npos[a]  <= clamped[a];
        s5_force[a] <= s4_force[a];
        s5_pos[a]   <= s4_pos[a];
      end
    end
  end

  // stage 6: cell index, result register
  logic [SUMW-1:0] cell_sum;

  logic [W-1:0]          s6_npos  [2];
  logic signed [W-1:0]   s6_force [2];
  logic [W-1:0]          s6_pos   [2];
  logic [CELL_W-1:0]     s6_cell;

  assign cell_sum = SUMW'(s5_npos[0][W-1:F])
                  + SUMW'(s5_npos[1][W-1:F]) * SUMW'(gw_eff);

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      for (int a = 0; a < 2; a++) begin
        s6_npos[a]  <= s5_npos[a];
        s6_force[a] <= s5_force[a];
        s6_pos[a]   <= s5_pos[a];
      end
      s6_cell <= CELL_W'(cell_sum);
    end
  end

  assign new_pos_x   = s6_npos[0];
  assign new_pos_y   = s6_npos[1];
  assign new_prev_x  = s6_pos[0];
  assign new_prev_y  = s6_pos[1];
  assign new_force_x = s6_force[0];
  assign new_force_y = s6_force[1];
  assign cell_index  = s6_cell;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NS-1] |-> !item_stall)
    else $error("input stalled with an empty result stage");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_lower_clamp_x: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> new_pos_x >= HALF)
    else $error("x position below the half cell margin");

  a_lower_clamp_y: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> new_pos_y >= HALF)
    else $error("y position below the half cell margin");

endmodule
